// File: rtl/core/scdm_pkg.sv
// ----------------------------------------------------------------------------
// scdm_pkg
// Shared widths, fixed-point constants and register indexes for the segment
// cosine diameter core.
// ----------------------------------------------------------------------------
package scdm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;

  // fixed-point format of cosine and diameter terms
  localparam int unsigned Q_FRAC = 26;
  localparam logic [Q_FRAC:0] Q_ONE = {1'b1, {Q_FRAC{1'b0}}};
  localparam logic [5:0] SHIFT_BIAS = 6'd6;

  // square root unit
  localparam int unsigned SQ_IN_W   = 62;
  localparam int unsigned SQ_ROOT_W = 31;
  localparam int unsigned SQ_SH_W   = 6;
  localparam int unsigned SQ_K_W    = 5;

  // divider unit
  localparam int unsigned DV_N_W   = 62;
  localparam int unsigned DV_D_W   = 30;
  localparam int unsigned DV_CNT_W = 6;

endpackage

// File: rtl/core/scdm_ram.sv
// ----------------------------------------------------------------------------
// scdm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/scdm_sqrt.sv
// ----------------------------------------------------------------------------
// scdm_sqrt
// Iterative normalize and integer square root: shifts the operand left by two
// until it reaches [2^60, 2^62), then resolves one root bit per cycle.
// ----------------------------------------------------------------------------
module scdm_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [scdm_pkg::SQ_IN_W-1:0]     operand,
  output logic                             busy,
  output logic                             done,
  output logic [scdm_pkg::SQ_ROOT_W-1:0]   root,
  output logic [scdm_pkg::SQ_SH_W-1:0]     shift
);

  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_NORM = 2'd1;
  localparam logic [1:0] SQ_ROOT = 2'd2;

  logic [1:0]                         st_r;
  logic [scdm_pkg::SQ_IN_W-1:0]       v_r;
  logic [scdm_pkg::SQ_IN_W:0]         r_r;
  logic [scdm_pkg::SQ_K_W-1:0]        k_r;
  logic [scdm_pkg::SQ_SH_W-1:0]       e_r;
  logic                               done_r;
  logic [scdm_pkg::SQ_IN_W:0]         bit_w;
  logic [scdm_pkg::SQ_IN_W:0]         trial_w;
  logic                               ge_w;

  assign bit_w   = (scdm_pkg::SQ_IN_W+1)'(1) << {k_r, 1'b0};
  assign trial_w = r_r + bit_w;
  assign ge_w    = {1'b0, v_r} >= trial_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SQ_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        SQ_IDLE: begin
          if (start) begin
            v_r  <= operand;
            e_r  <= '0;
            st_r <= SQ_NORM;
          end
        end
        SQ_NORM: begin
          if (v_r[scdm_pkg::SQ_IN_W-1 -: 2] == 2'b00) begin
            v_r <= {v_r[scdm_pkg::SQ_IN_W-3:0], 2'b00};
            e_r <= e_r + scdm_pkg::SQ_SH_W'(2);
          end else begin
            r_r  <= '0;
            k_r  <= scdm_pkg::SQ_K_W'(scdm_pkg::SQ_ROOT_W - 1);
            st_r <= SQ_ROOT;
          end
        end
        SQ_ROOT: begin
          if (ge_w) begin
            v_r <= v_r - trial_w[scdm_pkg::SQ_IN_W-1:0];
            r_r <= (r_r >> 1) + bit_w;
          end else begin
            r_r <= r_r >> 1;
          end
          k_r <= k_r - scdm_pkg::SQ_K_W'(1);
          if (k_r == '0) begin
            done_r <= 1'b1;
            st_r   <= SQ_IDLE;
          end
        end
        default: st_r <= SQ_IDLE;
      endcase
    end
  end

  assign busy  = (st_r != SQ_IDLE);
  assign done  = done_r;
  assign root  = r_r[scdm_pkg::SQ_ROOT_W-1:0];
  assign shift = e_r;

endmodule

// File: rtl/core/scdm_div.sv
// ----------------------------------------------------------------------------
// scdm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scdm_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [scdm_pkg::DV_N_W-1:0]    num,
  input  logic [scdm_pkg::DV_D_W-1:0]    den,
  output logic                           busy,
  output logic                           done,
  output logic [scdm_pkg::DV_N_W-1:0]    quo
);

  logic                               run_r;
  logic                               done_r;
  logic [scdm_pkg::DV_D_W-1:0]        den_r;
  logic [scdm_pkg::DV_D_W-1:0]        rem_r;
  logic [scdm_pkg::DV_N_W-1:0]        quo_r;
  logic [scdm_pkg::DV_CNT_W-1:0]      cnt_r;
  logic [scdm_pkg::DV_D_W:0]          trial_w;
  logic                               ge_w;

  assign trial_w = {rem_r, quo_r[scdm_pkg::DV_N_W-1]};
  assign ge_w    = trial_w >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!run_r) begin
        if (start) begin
          den_r <= den;
          rem_r <= '0;
          quo_r <= num;
          cnt_r <= scdm_pkg::DV_CNT_W'(scdm_pkg::DV_N_W - 1);
          run_r <= 1'b1;
        end
      end else begin
        rem_r <= ge_w ? scdm_pkg::DV_D_W'(trial_w - {1'b0, den_r})
                      : trial_w[scdm_pkg::DV_D_W-1:0];
        quo_r <= {quo_r[scdm_pkg::DV_N_W-2:0], ge_w};
        cnt_r <= cnt_r - scdm_pkg::DV_CNT_W'(1);
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: rtl/core/segment_cosine_diameter_matrix_core.sv
// ----------------------------------------------------------------------------
// segment_cosine_diameter_matrix_core
// Loads a sample matrix row-major, then walks every row segment and emits
// the sum of (1 - cosine to the segment mean)^2 over the segment's rows.
//
//   channel | dir | fields (low bit up)                        | handshake
//   in_     | in  | tdata: sample                              | tvalid/tready
//   out_    | out | tdata: diameter, seg_start, seg_end        | tvalid/tready
//           |     | tuser: degenerate; tlast: last             |
//   cfg_    | in  | index 0 rows_in_use, 1 cols_in_use         | wr_en
//
// Samples load one beat per cycle. After the final sample each segment
// forms its column sums, then the mean norm root (skipped if the norm is
// zero), then per row its dot product and norm, a normalize and 31-step
// root in the shared root unit and a 62-step divide (root and divide
// skipped on a zero norm), then EMIT. No sample is taken until all results
// are loaded into the output register; a stalled output holds the sequencer
// in EMIT.
// Reset is synchronous; no memory clearing pass.
// ----------------------------------------------------------------------------
module segment_cosine_diameter_matrix_core #(
  parameter int MAX_ROWS    = 8,
  parameter int MAX_COLS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // sample
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [39:0]                         out_tdata,  // diameter, seg_start, seg_end
  output logic                                out_tuser,  // degenerate
  output logic                                out_tlast,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [3:0]                          cfg_data
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = 16 + $clog2(MAX_ROWS) + 1;
  localparam int NSW   = 2 * SW + CW;
  localparam int NXW   = 31 + CW;
  localparam int DW    = 16 + SW + CW;
  localparam int SHR   = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;

  localparam logic [3:0] ST_LOAD      = 4'd0;
  localparam logic [3:0] ST_MS_RD     = 4'd1;
  localparam logic [3:0] ST_MS_ACC    = 4'd2;
  localparam logic [3:0] ST_MS_SQ     = 4'd3;
  localparam logic [3:0] ST_NS_ROOT   = 4'd4;
  localparam logic [3:0] ST_NS_WAIT   = 4'd5;
  localparam logic [3:0] ST_ROW_RD    = 4'd6;
  localparam logic [3:0] ST_ROW_MAC   = 4'd7;
  localparam logic [3:0] ST_ROW_CHK   = 4'd8;
  localparam logic [3:0] ST_ROW_ROOT  = 4'd9;
  localparam logic [3:0] ST_ROW_PDEN  = 4'd10;
  localparam logic [3:0] ST_ROW_SHIFT = 4'd11;
  localparam logic [3:0] ST_ROW_DIV   = 4'd12;
  localparam logic [3:0] ST_ROW_TERM  = 4'd13;
  localparam logic [3:0] ST_ROW_ACC   = 4'd14;
  localparam logic [3:0] ST_EMIT      = 4'd15;

  logic [3:0]                      state_r;
  logic [3:0]                      cfg_rows_r;
  logic [3:0]                      cfg_cols_r;
  logic [RW-1:0]                   ld_row_r;
  logic [CW-1:0]                   ld_col_r;
  logic [RW-1:0]                   seg_s_r;
  logic [RW-1:0]                   seg_e_r;
  logic [RW-1:0]                   row_r;
  logic [CW-1:0]                   col_r;
  logic signed [SW-1:0]            sacc_r;
  logic signed [SW-1:0]            s_r;
  logic [NSW-1:0]                  ns_r;
  logic [scdm_pkg::SQ_ROOT_W-1:0]  ss_r;
  logic [scdm_pkg::SQ_SH_W-1:0]    es_r;
  logic [NXW-1:0]                  nx_r;
  logic signed [DW-1:0]            dot_r;
  logic [scdm_pkg::SQ_ROOT_W-1:0]  sx_r;
  logic [scdm_pkg::SQ_SH_W-1:0]    ex_r;
  logic [scdm_pkg::DV_D_W-1:0]     pden_r;
  logic [scdm_pkg::DV_N_W-1:0]     mag_r;
  logic                            dneg_r;
  logic [scdm_pkg::DV_N_W-1:0]     q_r;
  logic [55:0]                     dd_r;
  logic [39:0]                     dia_r;
  logic                            degen_r;
  logic                            out_valid_r;
  logic [39:0]                     out_data_r;
  logic                            out_degen_r;
  logic                            out_last_r;

  logic [RW-1:0]                   rows_m1;
  logic [CW-1:0]                   cols_m1;
  logic signed [15:0]              smp_w;
  logic                            in_fire;
  logic                            samp_we;
  logic [AW-1:0]                   samp_waddr;
  logic [AW-1:0]                   samp_raddr;
  logic [15:0]                     samp_rd;
  logic                            mean_we;
  logic [SW-1:0]                   mean_rd;
  logic signed [15:0]              x_w;
  logic signed [SW-1:0]            sm_w;
  logic signed [SW-1:0]            sum_w;
  logic signed [31:0]              xx_w;
  logic signed [16+SW-1:0]         xs_w;
  logic signed [2*SW-1:0]          s2_w;
  logic [DW-1:0]                   dabs_w;
  logic [61:0]                     pprod_w;
  logic [6:0]                      hsum_w;
  logic [5:0]                      half_w;
  logic [123:0]                    wide_w;
  logic                            ovf_w;
  logic [scdm_pkg::DV_N_W-1:0]     n_w;
  logic [scdm_pkg::Q_FRAC:0]       qc_w;
  logic [27:0]                     d_w;
  logic [55:0]                     ddm_w;
  logic [56:0]                     rnd_w;
  logic                            out_free;
  logic                            seg_last;

  logic                            sq_start;
  logic [scdm_pkg::SQ_IN_W-1:0]    sq_in;
  logic                            sq_busy;
  logic                            sq_done;
  logic [scdm_pkg::SQ_ROOT_W-1:0]  sq_root;
  logic [scdm_pkg::SQ_SH_W-1:0]    sq_shift;
  logic                            dv_start;
  logic                            dv_busy;
  logic                            dv_done;
  logic [scdm_pkg::DV_N_W-1:0]     dv_quo;

  always_comb begin
    if (cfg_rows_r < 4'd2) begin
      rows_m1 = RW'(1);
    end else if (int'(cfg_rows_r) > MAX_ROWS) begin
      rows_m1 = RW'(MAX_ROWS - 1);
    end else begin
      rows_m1 = RW'(cfg_rows_r - 4'd1);
    end
    if (cfg_cols_r == 4'd0) begin
      cols_m1 = '0;
    end else if (int'(cfg_cols_r) > MAX_COLS) begin
      cols_m1 = CW'(MAX_COLS - 1);
    end else begin
      cols_m1 = CW'(cfg_cols_r - 4'd1);
    end
  end

  generate
    if (SAMPLE_BITS > 16) begin : g_trunc
      logic               neg_w;
      logic [SAMPLE_BITS:0] m_w;
      logic [SAMPLE_BITS:0] mt_w;
      assign neg_w = in_tdata[SAMPLE_BITS-1];
      assign m_w   = neg_w ? -{1'b1, in_tdata[SAMPLE_BITS-1:0]}
                           : {1'b0, in_tdata[SAMPLE_BITS-1:0]};
      assign mt_w  = m_w >> SHR;
      assign smp_w = neg_w ? -$signed(16'(mt_w)) : $signed(16'(mt_w));
    end else begin : g_ext
      assign smp_w = 16'($signed(in_tdata[SAMPLE_BITS-1:0]));
    end
  endgenerate

  assign in_tready  = (state_r == ST_LOAD);
  assign in_fire    = in_tvalid && in_tready;
  assign samp_we    = in_fire;
  assign samp_waddr = AW'(ld_row_r) * AW'(MAX_COLS) + AW'(ld_col_r);
  assign samp_raddr = AW'(row_r) * AW'(MAX_COLS) + AW'(col_r);
  assign mean_we    = (state_r == ST_MS_SQ);

  scdm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_samp_ram (
    .clk   (clk),
    .we    (samp_we),
    .waddr (samp_waddr),
    .wdata (smp_w),
    .raddr (samp_raddr),
    .rdata (samp_rd)
  );

  scdm_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_mean_ram (
    .clk   (clk),
    .we    (mean_we),
    .waddr (col_r),
    .wdata (s_r),
    .raddr (col_r),
    .rdata (mean_rd)
  );

  assign x_w    = $signed(samp_rd);
  assign sm_w   = $signed(mean_rd);
  assign sum_w  = sacc_r + SW'(x_w);
  assign xx_w   = x_w * x_w;
  assign xs_w   = x_w * sm_w;
  assign s2_w   = s_r * s_r;
  assign dabs_w = dot_r[DW-1] ? DW'(-dot_r) : DW'(dot_r);
  assign pprod_w = sx_r * ss_r;
  assign hsum_w = 7'(ex_r) + 7'(es_r);
  assign half_w = hsum_w[6:1];
  assign wide_w = {62'd0, mag_r} << (half_w - scdm_pkg::SHIFT_BIAS);
  assign ovf_w  = (half_w >= scdm_pkg::SHIFT_BIAS) && (|wide_w[123:62]);
  assign n_w    = (half_w < scdm_pkg::SHIFT_BIAS)
                  ? (mag_r >> (scdm_pkg::SHIFT_BIAS - half_w)) : wide_w[61:0];
  assign qc_w   = (q_r > 62'(scdm_pkg::Q_ONE)) ? scdm_pkg::Q_ONE
                                               : q_r[scdm_pkg::Q_FRAC:0];
  assign d_w    = dneg_r ? 28'(scdm_pkg::Q_ONE) + 28'(qc_w)
                         : 28'(scdm_pkg::Q_ONE) - 28'(qc_w);
  assign ddm_w  = d_w * d_w;
  assign rnd_w  = 57'(dd_r) + (57'(1) << (scdm_pkg::Q_FRAC - 1));
  assign out_free = !out_valid_r || out_tready;
  assign seg_last = (seg_s_r == rows_m1 - RW'(1)) && (seg_e_r == rows_m1);

  assign sq_start = ((state_r == ST_NS_ROOT) && (ns_r != '0)) ||
                    ((state_r == ST_ROW_CHK) && (nx_r != '0) && (ns_r != '0));
  assign sq_in    = (state_r == ST_NS_ROOT) ? scdm_pkg::SQ_IN_W'(ns_r)
                                            : scdm_pkg::SQ_IN_W'(nx_r);
  assign dv_start = (state_r == ST_ROW_SHIFT) && !ovf_w;

  scdm_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (sq_in),
    .busy    (sq_busy),
    .done    (sq_done),
    .root    (sq_root),
    .shift   (sq_shift)
  );

  scdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (n_w),
    .den   (pden_r),
    .busy  (dv_busy),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cfg_rows_r  <= 4'd8;
      cfg_cols_r  <= 4'd8;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      seg_s_r     <= '0;
      seg_e_r     <= RW'(1);
      dia_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (ld_col_r == cols_m1) begin
              ld_col_r <= '0;
              if (ld_row_r == rows_m1) begin
                ld_row_r <= '0;
                seg_s_r  <= '0;
                seg_e_r  <= RW'(1);
                row_r    <= '0;
                col_r    <= '0;
                sacc_r   <= '0;
                ns_r     <= '0;
                state_r  <= ST_MS_RD;
              end else begin
                ld_row_r <= ld_row_r + RW'(1);
              end
            end else begin
              ld_col_r <= ld_col_r + CW'(1);
            end
          end
        end
        ST_MS_RD: state_r <= ST_MS_ACC;
        ST_MS_ACC: begin
          if (row_r == seg_e_r) begin
            s_r     <= sum_w;
            state_r <= ST_MS_SQ;
          end else begin
            sacc_r  <= sum_w;
            row_r   <= row_r + RW'(1);
            state_r <= ST_MS_RD;
          end
        end
        ST_MS_SQ: begin
          ns_r <= ns_r + NSW'($unsigned(s2_w));
          if (col_r == cols_m1) begin
            state_r <= ST_NS_ROOT;
          end else begin
            col_r   <= col_r + CW'(1);
            row_r   <= seg_s_r;
            sacc_r  <= '0;
            state_r <= ST_MS_RD;
          end
        end
        ST_NS_ROOT: begin
          row_r   <= seg_s_r;
          col_r   <= '0;
          nx_r    <= '0;
          dot_r   <= '0;
          dia_r   <= '0;
          degen_r <= 1'b0;
          state_r <= (ns_r == '0) ? ST_ROW_RD : ST_NS_WAIT;
        end
        ST_NS_WAIT: begin
          if (sq_done) begin
            ss_r    <= sq_root;
            es_r    <= sq_shift;
            state_r <= ST_ROW_RD;
          end
        end
        ST_ROW_RD: state_r <= ST_ROW_MAC;
        ST_ROW_MAC: begin
          nx_r  <= nx_r + NXW'($unsigned(xx_w));
          dot_r <= dot_r + DW'(xs_w);
          if (col_r == cols_m1) begin
            state_r <= ST_ROW_CHK;
          end else begin
            col_r   <= col_r + CW'(1);
            state_r <= ST_ROW_RD;
          end
        end
        ST_ROW_CHK: begin
          if ((nx_r == '0) || (ns_r == '0)) begin
            dd_r    <= 56'(1) << (2 * scdm_pkg::Q_FRAC);
            degen_r <= 1'b1;
            state_r <= ST_ROW_ACC;
          end else begin
            state_r <= ST_ROW_ROOT;
          end
        end
        ST_ROW_ROOT: begin
          if (sq_done) begin
            sx_r    <= sq_root;
            ex_r    <= sq_shift;
            state_r <= ST_ROW_PDEN;
          end
        end
        ST_ROW_PDEN: begin
          pden_r  <= pprod_w[61:32];
          mag_r   <= scdm_pkg::DV_N_W'(dabs_w);
          dneg_r  <= dot_r[DW-1];
          state_r <= ST_ROW_SHIFT;
        end
        ST_ROW_SHIFT: begin
          if (ovf_w) begin
            q_r     <= scdm_pkg::DV_N_W'(scdm_pkg::Q_ONE);
            state_r <= ST_ROW_TERM;
          end else begin
            state_r <= ST_ROW_DIV;
          end
        end
        ST_ROW_DIV: begin
          if (dv_done) begin
            q_r     <= dv_quo;
            state_r <= ST_ROW_TERM;
          end
        end
        ST_ROW_TERM: begin
          dd_r    <= ddm_w;
          state_r <= ST_ROW_ACC;
        end
        ST_ROW_ACC: begin
          dia_r <= dia_r + 40'(rnd_w[56:scdm_pkg::Q_FRAC]);
          if (row_r == seg_e_r) begin
            state_r <= ST_EMIT;
          end else begin
            row_r   <= row_r + RW'(1);
            col_r   <= '0;
            nx_r    <= '0;
            dot_r   <= '0;
            state_r <= ST_ROW_RD;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {2'b00, 3'(seg_e_r), 3'(seg_s_r),
                            (|dia_r[39:32]) ? 32'hFFFF_FFFF : dia_r[31:0]};
            out_degen_r <= degen_r;
            out_last_r  <= seg_last;
            col_r       <= '0;
            sacc_r      <= '0;
            ns_r        <= '0;
            if (seg_last) begin
              seg_s_r <= '0;
              seg_e_r <= RW'(1);
              state_r <= ST_LOAD;
            end else if (seg_e_r == rows_m1) begin
              seg_s_r <= seg_s_r + RW'(1);
              seg_e_r <= seg_s_r + RW'(2);
              row_r   <= seg_s_r + RW'(1);
              state_r <= ST_MS_RD;
            end else begin
              seg_e_r <= seg_e_r + RW'(1);
              row_r   <= seg_s_r;
              state_r <= ST_MS_RD;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
      if (cfg_wr_en && (cfg_index == scdm_pkg::CFG_ROWS)) begin
        cfg_rows_r <= cfg_data;
        ld_row_r   <= '0;
        ld_col_r   <= '0;
      end
      if (cfg_wr_en && (cfg_index == scdm_pkg::CFG_COLS)) begin
        cfg_cols_r <= cfg_data;
        ld_row_r   <= '0;
        ld_col_r   <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_degen_r;
  assign out_tlast  = out_last_r;

  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!sq_busy && !dv_busy))
    else $error("arithmetic unit busy while loading");

  a_root_norm: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> sq_root[scdm_pkg::SQ_ROOT_W-1])
    else $error("root not normalized");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    dv_start |-> (pden_r != '0))
    else $error("divide by zero");

  a_last_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[37:35] == out_tdata[34:32] + 3'd1))
    else $error("final segment is not the last pair of rows");

endmodule
